>>> rtl/core/tpaf_pkg.sv
// Shared types, codes and delay tables for the triac phase-angle firing timer.
// Used by tpaf_engine and triac_phase_angle_firing; no dependencies.
package tpaf_pkg;

   localparam int COUNT_WIDTH_DEF = 16;
   localparam int PCT_WIDTH       = 7;
   localparam int DELAY_WIDTH     = 16;
   localparam int LEAD_WIDTH      = 15;
   localparam int PULSE_WIDTH     = 16;
   localparam int CSR_IDX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int PHASE_CODE_WIDTH = 2;

   localparam logic [PCT_WIDTH-1:0] PCT_MAX = 7'd100;

   // item kind on the request side
   localparam logic CMD_TICK       = 1'b0;
   localparam logic CMD_ZERO_CROSS = 1'b1;

   // register indexes on the csr port
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LINE_FREQ_SEL    = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ZERO_CROSS_LEAD  = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_GATE_PULSE_TICKS = 2'd2;

   localparam logic [LEAD_WIDTH-1:0]  LEAD_RESET  = 15'd800;
   localparam logic [PULSE_WIDTH-1:0] PULSE_RESET = 16'd100;

   // encoded phase as reported on the result word
   localparam logic [PHASE_CODE_WIDTH-1:0] CODE_DELAYING = 2'd0;
   localparam logic [PHASE_CODE_WIDTH-1:0] CODE_PULSE    = 2'd1;
   localparam logic [PHASE_CODE_WIDTH-1:0] CODE_DISABLED = 2'd2;

   typedef enum logic [2:0] {
      PH_DELAYING = 3'b001,
      PH_PULSE    = 3'b010,
      PH_DISABLED = 3'b100
   } phase_type;

   typedef struct packed {
      logic                   line_freq_sel;
      logic [LEAD_WIDTH-1:0]  zero_cross_lead;
      logic [PULSE_WIDTH-1:0] gate_pulse_ticks;
   } cfg_type;

   typedef struct packed {
      logic                        gate_on;
      logic [PHASE_CODE_WIDTH-1:0] phase;
   } result_type;

   // linearizing delay, indexed by percent, 50 Hz mains
   localparam logic [DELAY_WIDTH-1:0] DELAY50 [0:100] = '{
      16'd20000, 16'd17680, 16'd17061, 16'd16621, 16'd16265,
      16'd15961, 16'd15692, 16'd15448, 16'd15225, 16'd15017,
      16'd14822, 16'd14638, 16'd14462, 16'd14295, 16'd14134,
      16'd13979, 16'd13830, 16'd13685, 16'd13544, 16'd13407,
      16'd13274, 16'd13143, 16'd13016, 16'd12891, 16'd12768,
      16'd12647, 16'd12529, 16'd12412, 16'd12297, 16'd12184,
      16'd12072, 16'd11961, 16'd11851, 16'd11743, 16'd11636,
      16'd11529, 16'd11423, 16'd11319, 16'd11215, 16'd11111,
      16'd11008, 16'd10906, 16'd10804, 16'd10703, 16'd10602,
      16'd10501, 16'd10401, 16'd10300, 16'd10200, 16'd10100,
      16'd10000, 16'd9900,  16'd9800,  16'd9700,  16'd9599,
      16'd9499,  16'd9398,  16'd9297,  16'd9196,  16'd9094,
      16'd8992,  16'd8889,  16'd8785,  16'd8681,  16'd8577,
      16'd8471,  16'd8364,  16'd8257,  16'd8149,  16'd8039,
      16'd7928,  16'd7816,  16'd7703,  16'd7588,  16'd7471,
      16'd7353,  16'd7232,  16'd7109,  16'd6984,  16'd6857,
      16'd6726,  16'd6593,  16'd6456,  16'd6315,  16'd6170,
      16'd6021,  16'd5866,  16'd5705,  16'd5538,  16'd5362,
      16'd5178,  16'd4983,  16'd4775,  16'd4552,  16'd4308,
      16'd4039,  16'd3735,  16'd3379,  16'd2939,  16'd2320,
      16'd0
   };

   // same for 60 Hz mains
   localparam logic [DELAY_WIDTH-1:0] DELAY60 [0:100] = '{
      16'd16667, 16'd14733, 16'd14218, 16'd13851, 16'd13554,
      16'd13301, 16'd13076, 16'd12874, 16'd12687, 16'd12514,
      16'd12352, 16'd12198, 16'd12052, 16'd11912, 16'd11778,
      16'd11649, 16'd11525, 16'd11404, 16'd11287, 16'd11173,
      16'd11061, 16'd10953, 16'd10846, 16'd10742, 16'd10640,
      16'd10540, 16'd10441, 16'd10343, 16'd10248, 16'd10153,
      16'd10060, 16'd9967,  16'd9876,  16'd9786,  16'd9696,
      16'd9608,  16'd9520,  16'd9432,  16'd9346,  16'd9259,
      16'd9174,  16'd9088,  16'd9004,  16'd8919,  16'd8835,
      16'd8751,  16'd8667,  16'd8584,  16'd8500,  16'd8417,
      16'd8333,  16'd8250,  16'd8167,  16'd8083,  16'd8000,
      16'd7916,  16'd7832,  16'd7748,  16'd7663,  16'd7578,
      16'd7493,  16'd7407,  16'd7321,  16'd7234,  16'd7147,
      16'd7059,  16'd6970,  16'd6881,  16'd6791,  16'd6699,
      16'd6607,  16'd6514,  16'd6419,  16'd6323,  16'd6226,
      16'd6127,  16'd6027,  16'd5924,  16'd5820,  16'd5714,
      16'd5605,  16'd5494,  16'd5380,  16'd5263,  16'd5142,
      16'd5017,  16'd4888,  16'd4754,  16'd4615,  16'd4469,
      16'd4315,  16'd4153,  16'd3979,  16'd3793,  16'd3590,
      16'd3366,  16'd3113,  16'd2816,  16'd2449,  16'd1933,
      16'd0
   };

   function automatic logic [DELAY_WIDTH-1:0] delay_lookup(
      input logic                 sel60,
      input logic [PCT_WIDTH-1:0] pct
   );
      logic [PCT_WIDTH-1:0] idx;
      idx = (pct > PCT_MAX) ? PCT_MAX : pct;
      return sel60 ? DELAY60[idx] : DELAY50[idx];
   endfunction

   function automatic logic [PHASE_CODE_WIDTH-1:0] phase_code(input phase_type ph);
      logic [PHASE_CODE_WIDTH-1:0] code;
      unique case (ph)
         PH_DELAYING: code = CODE_DELAYING;
         PH_PULSE:    code = CODE_PULSE;
         default:     code = CODE_DISABLED;
      endcase
      return code;
   endfunction

endpackage

>>> rtl/core/tpaf_engine.sv
// Firing state: phase, tick counter and compare value, stepped once per word.
// Depends on tpaf_pkg.
module tpaf_engine
   import tpaf_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 cmd,
   input  logic [PCT_WIDTH-1:0] pct,
   input  cfg_type              cfg,
   output result_type           result
);

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] match_ff, match_in;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic [DELAY_WIDTH:0]   zc_sum;

   assign count_inc = count_ff + COUNT_WIDTH'(1);
   // table delay plus detector lead, wraps at the counter width
   assign zc_sum = {1'b0, delay_lookup(cfg.line_freq_sel, pct)}
                 + {2'b00, cfg.zero_cross_lead};

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      match_in = match_ff;
      if (step) begin
         if (cmd == CMD_ZERO_CROSS) begin
            phase_in = PH_DELAYING;
            count_in = '0;
            match_in = COUNT_WIDTH'(zc_sum);
         end else begin
            count_in = count_inc;
            if (count_inc == match_ff) begin
               unique case (phase_ff)
                  PH_DELAYING: begin
                     phase_in = PH_PULSE;
                     count_in = '0;
                     match_in = COUNT_WIDTH'(cfg.gate_pulse_ticks);
                  end
                  PH_PULSE: begin
                     phase_in = PH_DISABLED;
                     count_in = '0;
                     match_in = '1;
                  end
                  default: ;  // disabled: keep counting
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DISABLED;
         count_ff <= '0;
         match_ff <= '1;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         match_ff <= match_in;
      end
   end

   // state after this word, captured by the result register in the top level
   assign result.gate_on = (phase_in == PH_PULSE);
   assign result.phase   = phase_code(phase_in);

endmodule

>>> rtl/core/triac_phase_angle_firing.sv
// Top level of the triac phase-angle firing timer: stream ports, csr bank,
// input and result registers. Depends on tpaf_pkg and tpaf_engine.
//
//   channel | dir | handshake              | contents
//   --------+-----+------------------------+---------------------------------
//   req     | in  | req_tvalid/req_tready  | tuser cmd, tdata power_percent
//   rsp     | out | rsp_tvalid/rsp_tready  | tdata gate_on, firing_phase
//   csr     | in  | csr_valid/csr_ready    | csr_index, csr_wdata
//
// One word per cycle sustained while rsp_tready stays high; rsp_tvalid rises
// once its word has passed through both registers after acceptance (input
// register, then result register).
// The phase/counter update is one increment and compare in tpaf_engine.
// Reset: gate off, firing disabled, counter 0, compare all ones, csr
// registers at 50 Hz, lead 800, pulse 100.
// A stalled rsp side holds the result; the input register keeps one more
// word, after which req_tready drops.
module triac_phase_angle_firing
   import tpaf_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [6:0] power_percent, [7] zero
   input  logic                      req_tuser,   // [0] cmd

   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,   // [0] gate_on, [2:1] firing_phase,
                                                  // [7:3] zero

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   // csr bank
   cfg_type cfg_ff, cfg_in;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic                 in_cmd_ff;
   logic [PCT_WIDTH-1:0] in_pct_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;
   result_type step_result;

   logic advance;
   logic req_fire;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LINE_FREQ_SEL:    cfg_in.line_freq_sel    = csr_wdata[0];
            CSR_ZERO_CROSS_LEAD:  cfg_in.zero_cross_lead  = csr_wdata[LEAD_WIDTH-1:0];
            CSR_GATE_PULSE_TICKS: cfg_in.gate_pulse_ticks = csr_wdata[PULSE_WIDTH-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // the input word moves on when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_freq_sel    <= 1'b0;
         cfg_ff.zero_cross_lead  <= LEAD_RESET;
         cfg_ff.gate_pulse_ticks <= PULSE_RESET;
         in_valid_ff             <= 1'b0;
         out_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff <= req_tuser;
         in_pct_ff <= req_tdata[PCT_WIDTH-1:0];
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   tpaf_engine #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cmd    (in_cmd_ff),
      .pct    (in_pct_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b00000, out_data_ff.phase, out_data_ff.gate_on};

endmodule

>>> tb/tb.sv
// Self-checking bench for the triac phase-angle firing timer.
// Needs tpaf_pkg and the triac_phase_angle_firing RTL; holds a small firing
// tracker class plus the stream and csr drivers.
module tb;
   import tpaf_pkg::*;

   // Tracks the block's phase, counter and compare value, and holds the
   // result words that are due, oldest first.
   class gate_timer_model;
      logic                   sel60;
      logic [LEAD_WIDTH-1:0]  lead;
      logic [PULSE_WIDTH-1:0] pulse;
      logic [1:0]             phase;
      logic [15:0]            count;
      logic [15:0]            match;
      result_type             pending_gate[$];
      int                     errors;

      function new();
         sel60  = 1'b0;
         lead   = LEAD_RESET;
         pulse  = PULSE_RESET;
         phase  = CODE_DISABLED;
         count  = '0;
         match  = '1;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_WIDTH-1:0] idx,
                              logic [CSR_DATA_WIDTH-1:0] data);
         case (idx)
            CSR_LINE_FREQ_SEL:    sel60 = data[0];
            CSR_ZERO_CROSS_LEAD:  lead  = data[LEAD_WIDTH-1:0];
            CSR_GATE_PULSE_TICKS: pulse = data;
            default: ;
         endcase
      endfunction

      // Step the timer by one accepted request word.
      function void note_word(logic cmd, logic [PCT_WIDTH-1:0] pct);
         logic [PCT_WIDTH-1:0] idx;
         logic [15:0]          dly;
         result_type           res;
         if (cmd == CMD_ZERO_CROSS) begin
            idx   = (pct > PCT_MAX) ? PCT_MAX : pct;
            dly   = sel60 ? DELAY60[idx] : DELAY50[idx];
            count = '0;
            phase = CODE_DELAYING;
            match = dly + {1'b0, lead};
         end else begin
            // count first, then compare
            count = count + 16'd1;
            if (count == match) begin
               if (phase == CODE_DELAYING) begin
                  phase = CODE_PULSE;
                  count = '0;
                  match = pulse;
               end else if (phase == CODE_PULSE) begin
                  phase = CODE_DISABLED;
                  count = '0;
                  match = '1;
               end
            end
         end
         res.gate_on = (phase == CODE_PULSE);
         res.phase   = phase;
         pending_gate.push_back(res);
      endfunction

      task report_miss(string what, int got, int want);
         $display("MISMATCH %s: got %0d expected %0d", what, got, want);
         errors++;
      endtask

      task check_word(logic [7:0] word);
         result_type want;
         if (pending_gate.size() == 0) begin
            report_miss("result word with nothing due", word, 0);
         end else begin
            want = pending_gate.pop_front();
            if (word[0] !== want.gate_on)
               report_miss("gate_on", word[0], want.gate_on);
            if (word[2:1] !== want.phase)
               report_miss("firing_phase", word[2:1], want.phase);
            if (word[7:3] !== 5'd0)
               report_miss("pad bits", word[7:3], 0);
         end
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = '0;   // [6:0] power_percent, [7] zero
   logic                      req_tuser = 1'b0; // [0] cmd
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [7:0]                rsp_tdata;        // [0] gate_on, [2:1] firing_phase, [7:3] zero
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_WIDTH-1:0]  csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   gate_timer_model sb = new();

   int send_idle_pct  = 0;   // chance per cycle that the sender holds off
   int recv_stall_pct = 0;   // chance per cycle that rsp_tready is low
   int words_sent     = 0;

   triac_phase_angle_firing u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Result side: check the word taken at this edge, then pick the next
   // tready level. Values read here are the ones from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // One request word. tvalid stays high on exit so back-to-back words go
   // out without a bubble; whoever pauses the stream lowers it.
   task automatic send_word(input logic cmd, input logic [PCT_WIDTH-1:0] pct);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, pct};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(cmd, pct);
      words_sent++;
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_word(CMD_TICK, PCT_WIDTH'($urandom_range(127)));
   endtask

   // Stop the stream and let every due result come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_gate.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Registers only change once the block has gone quiet.
   task automatic set_config(input logic sel, input int lead, input int pulse);
      drain();
      write_csr(CSR_LINE_FREQ_SEL, {15'd0, sel});
      write_csr(CSR_ZERO_CROSS_LEAD, CSR_DATA_WIDTH'(lead));
      write_csr(CSR_GATE_PULSE_TICKS, CSR_DATA_WIDTH'(pulse));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly a zero cross at full power followed by enough ticks to walk
   // through delay, pulse and into disabled, cut off at a random point;
   // the rest is loose noise of any kind and percent.
   task automatic random_burst();
      logic [PCT_WIDTH-1:0] pct;
      if ($urandom_range(99) < 75) begin
         pct = ($urandom_range(3) == 0) ? PCT_WIDTH'($urandom_range(127))
                                        : PCT_WIDTH'($urandom_range(127, 100));
         send_word(CMD_ZERO_CROSS, pct);
         send_ticks($urandom_range(int'(sb.lead) + int'(sb.pulse) + 6));
      end else begin
         repeat ($urandom_range(6, 1))
            send_word(logic'($urandom_range(1)), PCT_WIDTH'($urandom_range(127)));
      end
   endtask

   initial begin
      int send_pcts[4];
      int recv_pcts[4];
      int target;
      int waited;
      int pct;
      send_pcts = '{0, 84, 0, 34};
      recv_pcts = '{0, 0, 84, 34};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // reset settings: tick while disabled, zero cross, one tick
      send_word(CMD_TICK, 7'd0);
      send_word(CMD_ZERO_CROSS, 7'd127);
      send_word(CMD_TICK, 7'd127);

      set_config(1'b0, 3, 2);
      send_word(CMD_TICK, 7'd0);
      send_word(CMD_ZERO_CROSS, 7'd127);  // above 100: saturates, delay 0
      send_ticks(3);                      // third tick fires the gate
      send_ticks(2);                      // pulse ends, firing disabled
      send_ticks(1);                      // disabled stays put
      send_word(CMD_ZERO_CROSS, 7'd100);
      send_ticks(4);                      // fire, then one tick into pulse
      send_word(CMD_ZERO_CROSS, 7'd0);    // zero cross during the pulse
      send_ticks(1);
      send_word(CMD_ZERO_CROSS, 7'd101);
      send_ticks(5);

      // --- random part, one idling pattern per phase ---
      target = words_sent;
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = send_pcts[p];
         recv_stall_pct = recv_pcts[p];
         set_config(logic'($urandom_range(1)), $urandom_range(12),
                    $urandom_range(8, 1));
         target += 120;
         while (words_sent < target) random_burst();
      end

      // --- short runs at full rate ---
      send_idle_pct  = 0;
      recv_stall_pct = 0;

      // largest lead and pulse, 60 Hz: compare values far off, then restart
      set_config(1'b1, 32767, 65535);
      send_word(CMD_ZERO_CROSS, 7'd0);
      send_ticks(3);
      send_word(CMD_ZERO_CROSS, 7'd100);
      send_ticks(3);

      // real table entries loaded, a few ticks into the delay
      repeat (2) begin
         set_config(logic'($urandom_range(1)), $urandom_range(12),
                    $urandom_range(8, 1));
         pct = $urandom_range(99);
         send_word(CMD_ZERO_CROSS, PCT_WIDTH'(pct));
         send_ticks(4);
      end

      // compare of 0: no match until the counter would wrap
      set_config(1'b0, 0, 0);
      send_word(CMD_ZERO_CROSS, 7'd127);
      send_ticks(4);

      // --- wind down ---
      req_tvalid <= 1'b0;
      waited = 0;
      while (sb.pending_gate.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (sb.pending_gate.size() != 0)
         sb.report_miss("result words never seen", 0, sb.pending_gate.size());

      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #30000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
